// File: hw/rtl/uerd_pkg.sv
// Shared types, widths and constants for the ultrasonic echo range detector.
// Used by every RTL module of the block and by its checker. No dependencies.
package uerd_pkg;

	// Field widths
	localparam int SAMPLE_W   = 12;
	localparam int INDEX_W    = 14;
	localparam int SIDX_W     = INDEX_W + 1;
	localparam int THR_W      = 12;
	localparam int SCALE_W    = 20;
	localparam int OFFSET_W   = 20;
	localparam int DIST_W     = 26;
	localparam int STATUS_W   = 2;
	localparam int ACTION_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// Baseline averaging window
	localparam int BASELINE_WINDOW = 100;
	localparam int BSUM_W      = $clog2(BASELINE_WINDOW * ((1 << SAMPLE_W) - 1) + 1);
	localparam int BCNT_W      = $clog2(BASELINE_WINDOW + 1);
	localparam int WEND_W      = SIDX_W + 1;
	// Reciprocal for the divide by the window length; exact for sums below 2^12 * window
	localparam int RECIP_SHIFT = 27;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + BASELINE_WINDOW - 1) / BASELINE_WINDOW;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int QPROD_W     = BSUM_W + RECIP_W;

	// Distance arithmetic
	localparam int DSCALE_SHIFT = 8;
	localparam int MPROD_W      = SIDX_W + SCALE_W;
	localparam int SCALED_W     = MPROD_W - DSCALE_SHIFT;
	localparam logic [DIST_W-1:0] DIST_FLOOR_UM = DIST_W'(1000);

	// Reset values
	localparam logic [SAMPLE_W-1:0] BASELINE_RESET   = SAMPLE_W'(100);
	localparam logic [THR_W-1:0]    RST_THRESHOLD    = THR_W'(150);
	localparam logic [INDEX_W-1:0]  RST_DEAD_ZONE    = INDEX_W'(500);
	localparam logic [INDEX_W-1:0]  RST_PEAK_END     = INDEX_W'(2000);
	localparam logic [INDEX_W-1:0]  RST_BASE_START   = INDEX_W'(5000);
	localparam logic [INDEX_W-1:0]  RST_STOP_INDEX   = INDEX_W'(8000);
	localparam logic [SCALE_W-1:0]  RST_SCALE_Q8     = SCALE_W'(184729);
	localparam logic [OFFSET_W-1:0] RST_OFFSET_UM    = OFFSET_W'(30000);

	// Request action codes
	localparam logic [ACTION_W-1:0] ACT_START  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_ACK    = 2'd2;

	// Reported capture status codes
	localparam logic [STATUS_W-1:0] STATUS_IDLE   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SEARCH = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_END       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_START     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_INDEX     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q8       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_UM      = 3'd6;

	// Capture sequencer
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_DONE   = 3'b100
	} capture_state_t;

	typedef struct packed {
		logic [THR_W-1:0]    echo_threshold;
		logic [INDEX_W-1:0]  dead_zone_samples;
		logic [INDEX_W-1:0]  peak_window_end;
		logic [INDEX_W-1:0]  baseline_start;
		logic [INDEX_W-1:0]  stop_index;
		logic [SCALE_W-1:0]  distance_scale_q8;
		logic [OFFSET_W-1:0] distance_offset_um;
	} cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] capture_status;
		logic                echo_found;
		logic [DIST_W-1:0]   distance_um;
		logic [SAMPLE_W-1:0] baseline_level;
		logic [SAMPLE_W-1:0] first_valid_sample;
		logic [SAMPLE_W-1:0] peak_sample;
		logic [INDEX_W-1:0]  peak_index;
	} res_t;

	// Sum divided by the window length, truncating
	function automatic logic [SAMPLE_W-1:0] div_window(input logic [BSUM_W-1:0] sum);
		logic [QPROD_W-1:0] prod;
		prod = QPROD_W'(sum) * QPROD_W'(RECIP);
		return prod[RECIP_SHIFT +: SAMPLE_W];
	endfunction

endpackage

// File: hw/rtl/uerd_cfg_regs.sv
// Configuration register file of the echo range detector.
// Depends on uerd_pkg for the register indexes, widths and reset values.
module uerd_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [uerd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [uerd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output uerd_pkg::cfg_t                      cfg
);

	uerd_pkg::cfg_t cfg_q;

	// Always ready: writes are never stalled
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.echo_threshold     <= uerd_pkg::RST_THRESHOLD;
			cfg_q.dead_zone_samples  <= uerd_pkg::RST_DEAD_ZONE;
			cfg_q.peak_window_end    <= uerd_pkg::RST_PEAK_END;
			cfg_q.baseline_start     <= uerd_pkg::RST_BASE_START;
			cfg_q.stop_index         <= uerd_pkg::RST_STOP_INDEX;
			cfg_q.distance_scale_q8  <= uerd_pkg::RST_SCALE_Q8;
			cfg_q.distance_offset_um <= uerd_pkg::RST_OFFSET_UM;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				uerd_pkg::CFG_ECHO_THRESHOLD: begin
					cfg_q.echo_threshold <= cfg_data[uerd_pkg::THR_W-1:0];
				end
				uerd_pkg::CFG_DEAD_ZONE: begin
					cfg_q.dead_zone_samples <= cfg_data[uerd_pkg::INDEX_W-1:0];
				end
				uerd_pkg::CFG_PEAK_END: begin
					cfg_q.peak_window_end <= cfg_data[uerd_pkg::INDEX_W-1:0];
				end
				uerd_pkg::CFG_BASE_START: begin
					cfg_q.baseline_start <= cfg_data[uerd_pkg::INDEX_W-1:0];
				end
				uerd_pkg::CFG_STOP_INDEX: begin
					cfg_q.stop_index <= cfg_data[uerd_pkg::INDEX_W-1:0];
				end
				uerd_pkg::CFG_SCALE_Q8: begin
					cfg_q.distance_scale_q8 <= cfg_data[uerd_pkg::SCALE_W-1:0];
				end
				uerd_pkg::CFG_OFFSET_UM: begin
					cfg_q.distance_offset_um <= cfg_data[uerd_pkg::OFFSET_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/uerd_dist.sv
// Time-of-flight to distance conversion: index times Q8 scale, minus offset.
// Depends on uerd_pkg for widths and the zero-distance substitute.
module uerd_dist (
	input  logic [uerd_pkg::SIDX_W-1:0]   sample_index,
	input  logic [uerd_pkg::SCALE_W-1:0]  distance_scale_q8,
	input  logic [uerd_pkg::OFFSET_W-1:0] distance_offset_um,
	output logic [uerd_pkg::DIST_W-1:0]   distance_um
);

	logic [uerd_pkg::MPROD_W-1:0]  prod;
	logic [uerd_pkg::SCALED_W-1:0] scaled;
	logic [uerd_pkg::SCALED_W-1:0] offset_ext;
	logic [uerd_pkg::SCALED_W-1:0] diff;

	// Q8 product, fraction dropped
	assign prod       = uerd_pkg::MPROD_W'(sample_index) * uerd_pkg::MPROD_W'(distance_scale_q8);
	assign scaled     = prod[uerd_pkg::MPROD_W-1:uerd_pkg::DSCALE_SHIFT];
	assign offset_ext = uerd_pkg::SCALED_W'(distance_offset_um);
	assign diff       = scaled - offset_ext;

	// Clamp at zero; a zero distance reads as the floor value
	assign distance_um = (scaled > offset_ext) ? diff[uerd_pkg::DIST_W-1:0]
		: uerd_pkg::DIST_FLOOR_UM;

endmodule

// File: hw/rtl/uerd_core.sv
// Capture state and per-sample update logic of the echo range detector.
// Depends on uerd_pkg and instantiates uerd_dist.
module uerd_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [uerd_pkg::ACTION_W-1:0]     action,
	input  logic [uerd_pkg::SAMPLE_W-1:0]     sample,
	input  uerd_pkg::cfg_t                    cfg,
	output uerd_pkg::res_t                    res_nxt
);

	uerd_pkg::capture_state_t          state_q, state_n;
	logic [uerd_pkg::SIDX_W-1:0]       sidx_q, sidx_n;
	logic [uerd_pkg::BSUM_W-1:0]       bsum_q, bsum_n;
	logic [uerd_pkg::BCNT_W-1:0]       bcnt_q, bcnt_n;
	logic [uerd_pkg::SAMPLE_W-1:0]     bavg_q, bavg_n;
	logic [uerd_pkg::SAMPLE_W-1:0]     first_q, first_n;
	logic [uerd_pkg::SAMPLE_W-1:0]     peak_q, peak_n;
	logic [uerd_pkg::INDEX_W-1:0]      pidx_q, pidx_n;
	logic [uerd_pkg::DIST_W-1:0]       dist_q, dist_n;
	logic                              latched_q, latched_n;

	logic [uerd_pkg::DIST_W-1:0]       dist_calc;
	logic [uerd_pkg::WEND_W-1:0]       win_end;
	logic [uerd_pkg::BSUM_W-1:0]       bsum_add;
	logic [uerd_pkg::BCNT_W-1:0]       bcnt_inc;
	logic [uerd_pkg::SAMPLE_W:0]       echo_level;
	logic                              past_stop;
	logic                              in_window;
	logic                              past_dz;
	logic                              at_dz;
	logic                              in_peak;
	logic                              echo_hit;
	logic [uerd_pkg::STATUS_W-1:0]     status_n;

	// Distance for the current index
	uerd_dist u_dist (
		.sample_index       (sidx_q),
		.distance_scale_q8  (cfg.distance_scale_q8),
		.distance_offset_um (cfg.distance_offset_um),
		.distance_um        (dist_calc)
	);

	// Index window compares
	assign win_end   = uerd_pkg::WEND_W'(cfg.baseline_start)
		+ uerd_pkg::WEND_W'(uerd_pkg::BASELINE_WINDOW);
	assign past_stop = sidx_q > uerd_pkg::SIDX_W'(cfg.stop_index);
	assign in_window = (sidx_q >= uerd_pkg::SIDX_W'(cfg.baseline_start))
		&& (uerd_pkg::WEND_W'(sidx_q) < win_end);
	assign past_dz   = sidx_q >= uerd_pkg::SIDX_W'(cfg.dead_zone_samples);
	assign at_dz     = sidx_q == uerd_pkg::SIDX_W'(cfg.dead_zone_samples);
	assign in_peak   = sidx_q < uerd_pkg::SIDX_W'(cfg.peak_window_end);

	// Baseline accumulation and echo threshold
	assign bsum_add   = bsum_q + uerd_pkg::BSUM_W'(sample);
	assign bcnt_inc   = bcnt_q + uerd_pkg::BCNT_W'(1);
	assign echo_level = {1'b0, bavg_q} + {1'b0, cfg.echo_threshold};
	assign echo_hit   = {1'b0, sample} > echo_level;

	// Next state for the request in flight
	always_comb begin
		state_n   = state_q;
		sidx_n    = sidx_q;
		bsum_n    = bsum_q;
		bcnt_n    = bcnt_q;
		bavg_n    = bavg_q;
		first_n   = first_q;
		peak_n    = peak_q;
		pidx_n    = pidx_q;
		dist_n    = dist_q;
		latched_n = latched_q;
		unique case (action)
			uerd_pkg::ACT_START: begin
				if (state_q == uerd_pkg::ST_IDLE) begin
					state_n   = uerd_pkg::ST_SEARCH;
					sidx_n    = '0;
					bsum_n    = '0;
					bcnt_n    = '0;
					peak_n    = '0;
					pidx_n    = '0;
					dist_n    = '0;
					latched_n = 1'b0;
				end
			end
			uerd_pkg::ACT_SAMPLE: begin
				if (state_q == uerd_pkg::ST_SEARCH) begin
					if (past_stop) begin
						// sample dropped, capture over
						state_n = uerd_pkg::ST_DONE;
					end else begin
						if (in_window) begin
							bsum_n = bsum_add;
							bcnt_n = bcnt_inc;
							if (bcnt_inc == uerd_pkg::BCNT_W'(uerd_pkg::BASELINE_WINDOW)) begin
								bavg_n = uerd_pkg::div_window(bsum_add);
							end
						end
						if (past_dz) begin
							if (at_dz) begin
								first_n = sample;
							end
							if (in_peak && (sample > peak_q)) begin
								peak_n = sample;
								pidx_n = sidx_q[uerd_pkg::INDEX_W-1:0];
							end
							if (!latched_q && echo_hit) begin
								dist_n    = dist_calc;
								latched_n = 1'b1;
							end
						end
						sidx_n = sidx_q + uerd_pkg::SIDX_W'(1);
					end
				end
			end
			uerd_pkg::ACT_ACK: begin
				if (state_q == uerd_pkg::ST_DONE) begin
					state_n = uerd_pkg::ST_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

	// Status code of the next state
	always_comb begin
		unique case (state_n)
			uerd_pkg::ST_SEARCH: status_n = uerd_pkg::STATUS_SEARCH;
			uerd_pkg::ST_DONE:   status_n = uerd_pkg::STATUS_DONE;
			default:             status_n = uerd_pkg::STATUS_IDLE;
		endcase
	end

	assign res_nxt.capture_status     = status_n;
	assign res_nxt.echo_found         = latched_n;
	assign res_nxt.distance_um        = dist_n;
	assign res_nxt.baseline_level     = bavg_n;
	assign res_nxt.first_valid_sample = first_n;
	assign res_nxt.peak_sample        = peak_n;
	assign res_nxt.peak_index         = pidx_n;

	// Capture state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= uerd_pkg::ST_IDLE;
			sidx_q    <= '0;
			bsum_q    <= '0;
			bcnt_q    <= '0;
			bavg_q    <= uerd_pkg::BASELINE_RESET;
			first_q   <= '0;
			peak_q    <= '0;
			pidx_q    <= '0;
			dist_q    <= '0;
			latched_q <= 1'b0;
		end else if (step) begin
			state_q   <= state_n;
			sidx_q    <= sidx_n;
			bsum_q    <= bsum_n;
			bcnt_q    <= bcnt_n;
			bavg_q    <= bavg_n;
			first_q   <= first_n;
			peak_q    <= peak_n;
			pidx_q    <= pidx_n;
			dist_q    <= dist_n;
			latched_q <= latched_n;
		end
	end

endmodule

// File: hw/rtl/ultrasonic_echo_range_detector.sv
// Ultrasonic echo range detector, top level: request register, result register, handshake.
// Depends on uerd_pkg; instantiates uerd_cfg_regs and uerd_core.
//
// Usage:
//  - Request channel (in_valid/in_ready): action 0 starts a capture from idle, action 1
//    delivers one ADC sample, action 2 acknowledges a finished capture.
//  - Result channel (out_valid/out_ready): one result per request, showing status,
//    echo distance, baseline, dead-zone sample and peak after that request.
//  - Configuration channel (cfg_valid/cfg_ready): always ready, one register per write;
//    write only while no request is outstanding.
//  - Flow: an accepted request waits in the request register until the result register is
//    free or being emptied; its result is then loaded there and out_valid is high from then on.
//  - Throughput: one request per cycle while out_ready stays high. Each request passes through
//    a single stage of compare, add and multiply logic between the request and result registers.
//  - If the receiver stalls, the held result and one pending request fill the two
//    registers and in_ready drops until out_ready returns.
//  - Reset: capture idle, baseline 100, registers at their documented defaults,
//    both pipeline registers empty.
module ultrasonic_echo_range_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [uerd_pkg::ACTION_W-1:0]       action,
	input  logic [uerd_pkg::SAMPLE_W-1:0]       sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [uerd_pkg::STATUS_W-1:0]       capture_status,
	output logic                                echo_found,
	output logic [uerd_pkg::DIST_W-1:0]         distance_um,
	output logic [uerd_pkg::SAMPLE_W-1:0]       baseline_level,
	output logic [uerd_pkg::SAMPLE_W-1:0]       first_valid_sample,
	output logic [uerd_pkg::SAMPLE_W-1:0]       peak_sample,
	output logic [uerd_pkg::INDEX_W-1:0]        peak_index,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [uerd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [uerd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	uerd_pkg::cfg_t                    cfg;
	uerd_pkg::res_t                    res_nxt;
	uerd_pkg::res_t                    res_q;
	logic                              valid_s1;
	logic [uerd_pkg::ACTION_W-1:0]     action_s1;
	logic [uerd_pkg::SAMPLE_W-1:0]     sample_s1;
	logic                              out_valid_q;
	logic                              advance;
	logic                              in_take;

	uerd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uerd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.action  (action_s1),
		.sample  (sample_s1),
		.cfg     (cfg),
		.res_nxt (res_nxt)
	);

	// Request moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			sample_s1 <= sample;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid          = out_valid_q;
	assign capture_status     = res_q.capture_status;
	assign echo_found         = res_q.echo_found;
	assign distance_um        = res_q.distance_um;
	assign baseline_level     = res_q.baseline_level;
	assign first_valid_sample = res_q.first_valid_sample;
	assign peak_sample        = res_q.peak_sample;
	assign peak_index         = res_q.peak_index;

endmodule

// File: hw/rtl/uerd_checker.sv
// Port-level checks for the echo range detector and their bind to the top level.
// Depends on uerd_pkg; attaches to ultrasonic_echo_range_detector.
module uerd_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [uerd_pkg::STATUS_W-1:0]       capture_status,
	input  logic                                echo_found,
	input  logic [uerd_pkg::DIST_W-1:0]         distance_um,
	input  logic [uerd_pkg::SAMPLE_W-1:0]       peak_sample,
	input  logic [uerd_pkg::INDEX_W-1:0]        peak_index
);

	// A stalled result holds
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(capture_status)
			&& $stable(distance_um) && $stable(peak_sample))
		else $error("stalled result changed");

	// No echo means no latched distance
	a_no_echo_no_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !echo_found |-> distance_um == '0)
		else $error("distance reported without an echo");

	// A latched echo always carries a non-zero distance
	a_echo_has_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && echo_found |-> distance_um != '0)
		else $error("echo latched with zero distance");

	// Peak index only moves together with a non-zero peak
	a_peak_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (peak_sample == '0) |-> peak_index == '0)
		else $error("peak index set without a peak");

endmodule

bind ultrasonic_echo_range_detector uerd_checker u_uerd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.capture_status (capture_status),
	.echo_found     (echo_found),
	.distance_um    (distance_um),
	.peak_sample    (peak_sample),
	.peak_index     (peak_index)
);

// File: sim/testbench.sv
// Self-checking testbench for ultrasonic_echo_range_detector: request and result streams
// with random stalls, register writes between phases, and an in-bench capture predictor.
// Depends on uerd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
	import uerd_pkg::*;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 9;
	localparam int RANDOM_ITEMS  = 650;
	localparam int IDLE_PCT      = 23;
	localparam int STEADY_FROM   = 120;
	localparam int STEADY_TO     = 260;
	localparam int HOLD_AT       = 330;
	localparam int HOLD_CYCLES   = 90;
	localparam int HOLD_BACKLOG  = 4;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 300000;

	// Action code the block does not decode, and a register index with no register behind it
	localparam logic [ACTION_W-1:0]  ACT_RESERVED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [SAMPLE_W-1:0] amp;
	} echo_request_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [ACTION_W-1:0]   action = ACT_START;
	logic [SAMPLE_W-1:0]   sample = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [STATUS_W-1:0]   capture_status;
	logic                  echo_found;
	logic [DIST_W-1:0]     distance_um;
	logic [SAMPLE_W-1:0]   baseline_level;
	logic [SAMPLE_W-1:0]   first_valid_sample;
	logic [SAMPLE_W-1:0]   peak_sample;
	logic [INDEX_W-1:0]    peak_index;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	echo_request_t queued_requests[$];
	res_t          due_readings[$];
	int unsigned   planned;
	int unsigned   accepted;
	int unsigned   mismatches;
	int unsigned   cycles;
	int unsigned   hold_left;

	// Predictor copy of the registers and capture state
	cfg_t                 live_cfg;
	capture_state_t       sim_state;
	logic [SIDX_W-1:0]    sim_index;
	logic [BSUM_W-1:0]    sim_bsum;
	logic [BCNT_W-1:0]    sim_bcount;
	logic [SAMPLE_W-1:0]  sim_bavg;
	logic [SAMPLE_W-1:0]  sim_first;
	logic [SAMPLE_W-1:0]  sim_peak;
	logic [INDEX_W-1:0]   sim_peak_pos;
	logic [DIST_W-1:0]    sim_dist;
	logic                 sim_latched;

	ultrasonic_echo_range_detector u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.action             (action),
		.sample             (sample),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.capture_status     (capture_status),
		.echo_found         (echo_found),
		.distance_um        (distance_um),
		.baseline_level     (baseline_level),
		.first_valid_sample (first_valid_sample),
		.peak_sample        (peak_sample),
		.peak_index         (peak_index),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	task automatic report_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Time of flight to micrometres, clamped at zero, zero mapped to the floor value
	function automatic logic [DIST_W-1:0] echo_range_um(input int unsigned pos);
		logic [63:0] span;
		span = (64'(pos) * 64'(live_cfg.distance_scale_q8)) >> DSCALE_SHIFT;
		if (span > 64'(live_cfg.distance_offset_um)) begin
			span = span - 64'(live_cfg.distance_offset_um);
		end else begin
			span = '0;
		end
		if (span == 0) begin
			return DIST_FLOOR_UM;
		end
		return span[DIST_W-1:0];
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_ECHO_THRESHOLD: live_cfg.echo_threshold = data[THR_W-1:0];
			CFG_DEAD_ZONE:      live_cfg.dead_zone_samples = data[INDEX_W-1:0];
			CFG_PEAK_END:       live_cfg.peak_window_end = data[INDEX_W-1:0];
			CFG_BASE_START:     live_cfg.baseline_start = data[INDEX_W-1:0];
			CFG_STOP_INDEX:     live_cfg.stop_index = data[INDEX_W-1:0];
			CFG_SCALE_Q8:       live_cfg.distance_scale_q8 = data[SCALE_W-1:0];
			CFG_OFFSET_UM:      live_cfg.distance_offset_um = data[OFFSET_W-1:0];
			default: ;
		endcase
	endfunction

	// Advance the capture by one request and return the reading it should produce
	function automatic res_t advance_capture(input logic [ACTION_W-1:0] act,
			input logic [SAMPLE_W-1:0] amp);
		res_t        r;
		int unsigned pos;
		int unsigned bstart;
		pos = sim_index;
		bstart = live_cfg.baseline_start;
		case (act)
			ACT_START: begin
				if (sim_state == ST_IDLE) begin
					sim_state = ST_SEARCH;
					sim_index = '0;
					sim_bsum = '0;
					sim_bcount = '0;
					sim_peak = '0;
					sim_peak_pos = '0;
					sim_dist = '0;
					sim_latched = 1'b0;
				end
			end
			ACT_SAMPLE: begin
				if (sim_state == ST_SEARCH) begin
					if (pos > live_cfg.stop_index) begin
						// past the end of the capture: sample dropped
						sim_state = ST_DONE;
					end else begin
						if (pos >= bstart && pos < bstart + BASELINE_WINDOW) begin
							sim_bsum = sim_bsum + BSUM_W'(amp);
							sim_bcount = sim_bcount + 1'b1;
							if (sim_bcount == BASELINE_WINDOW) begin
								sim_bavg = SAMPLE_W'(sim_bsum / BASELINE_WINDOW);
							end
						end
						if (pos >= live_cfg.dead_zone_samples) begin
							if (pos == live_cfg.dead_zone_samples) begin
								sim_first = amp;
							end
							if (pos < live_cfg.peak_window_end && amp > sim_peak) begin
								sim_peak = amp;
								sim_peak_pos = INDEX_W'(pos);
							end
							// threshold formed one bit wider so it cannot wrap
							if (!sim_latched && {1'b0, amp} >
									({1'b0, sim_bavg} + {1'b0, live_cfg.echo_threshold})) begin
								sim_dist = echo_range_um(pos);
								sim_latched = 1'b1;
							end
						end
						sim_index = sim_index + 1'b1;
					end
				end
			end
			ACT_ACK: begin
				if (sim_state == ST_DONE) begin
					sim_state = ST_IDLE;
				end
			end
			default: ;
		endcase
		case (sim_state)
			ST_SEARCH: r.capture_status = STATUS_SEARCH;
			ST_DONE:   r.capture_status = STATUS_DONE;
			default:   r.capture_status = STATUS_IDLE;
		endcase
		r.echo_found = sim_latched;
		r.distance_um = sim_dist;
		r.baseline_level = sim_bavg;
		r.first_valid_sample = sim_first;
		r.peak_sample = sim_peak;
		r.peak_index = sim_peak_pos;
		return r;
	endfunction

	task automatic queue_request(input logic [ACTION_W-1:0] act, input logic [SAMPLE_W-1:0] amp);
		echo_request_t req;
		req.act = act;
		req.amp = amp;
		queued_requests.push_back(req);
		planned++;
	endtask

	function automatic logic [ACTION_W-1:0] stray_action();
		case ($urandom_range(2))
			0:       return ACT_START;
			1:       return ACT_ACK;
			default: return ACT_RESERVED;
		endcase
	endfunction

	// Register write on the configuration channel; shadow updated at the handshake
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
		cfg_valid <= 1'b0;
	endtask

	// Hold the sender back until every reading is in, then let the block settle
	task automatic wait_drained();
		while (queued_requests.size() != 0 || in_valid || due_readings.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic bit steady_phase();
		return accepted >= STEADY_FROM && accepted < STEADY_TO;
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		echo_request_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				due_readings.push_back(advance_capture(action, sample));
				accepted++;
			end
			if (!in_valid || in_ready) begin
				if (queued_requests.size() != 0 &&
						(steady_phase() || $urandom_range(99) >= IDLE_PCT)) begin
					req = queued_requests.pop_front();
					in_valid <= 1'b1;
					action <= req.act;
					sample <= req.amp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold-off while a capture is still queued, so the block backs up
	initial begin
		hold_left = 0;
		@(posedge arst_n);
		do @(posedge clk); while (accepted < HOLD_AT || queued_requests.size() < HOLD_BACKLOG);
		hold_left = HOLD_CYCLES;
		while (hold_left != 0) begin
			@(posedge clk);
			hold_left--;
		end
	end

	// Result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_readings.size() == 0) begin
					report_error("reading with no request outstanding");
				end else begin
					want = due_readings.pop_front();
					if (capture_status !== want.capture_status)
						report_error($sformatf("capture_status %0d, want %0d",
							capture_status, want.capture_status));
					if (echo_found !== want.echo_found)
						report_error($sformatf("echo_found %0d, want %0d",
							echo_found, want.echo_found));
					if (distance_um !== want.distance_um)
						report_error($sformatf("distance_um %0d, want %0d",
							distance_um, want.distance_um));
					if (baseline_level !== want.baseline_level)
						report_error($sformatf("baseline_level %0d, want %0d",
							baseline_level, want.baseline_level));
					if (first_valid_sample !== want.first_valid_sample)
						report_error($sformatf("first_valid_sample %0d, want %0d",
							first_valid_sample, want.first_valid_sample));
					if (peak_sample !== want.peak_sample)
						report_error($sformatf("peak_sample %0d, want %0d",
							peak_sample, want.peak_sample));
					if (peak_index !== want.peak_index)
						report_error($sformatf("peak_index %0d, want %0d",
							peak_index, want.peak_index));
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady_phase() || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Stimulus: directed opening, then random capture phases
	initial begin
		int unsigned stop_at;
		int unsigned thr;
		int unsigned stop;
		int unsigned bstart;
		int unsigned dead;
		int unsigned pend;
		int unsigned scale;
		int unsigned offs;

		live_cfg.echo_threshold = RST_THRESHOLD;
		live_cfg.dead_zone_samples = RST_DEAD_ZONE;
		live_cfg.peak_window_end = RST_PEAK_END;
		live_cfg.baseline_start = RST_BASE_START;
		live_cfg.stop_index = RST_STOP_INDEX;
		live_cfg.distance_scale_q8 = RST_SCALE_Q8;
		live_cfg.distance_offset_um = RST_OFFSET_UM;
		sim_state = ST_IDLE;
		sim_index = '0;
		sim_bsum = '0;
		sim_bcount = '0;
		sim_bavg = BASELINE_RESET;
		sim_first = '0;
		sim_peak = '0;
		sim_peak_pos = '0;
		sim_dist = '0;
		sim_latched = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: ignored actions in idle and search, then a few samples
		queue_request(ACT_ACK, 12'h000);
		queue_request(ACT_SAMPLE, 12'hFFF);
		queue_request(ACT_RESERVED, 12'hFFF);
		queue_request(ACT_START, 12'h000);
		queue_request(ACT_START, 12'hFFF);
		queue_request(ACT_SAMPLE, 12'hFFF);
		queue_request(ACT_SAMPLE, 12'h000);
		queue_request(ACT_SAMPLE, 12'hAAA);
		queue_request(ACT_SAMPLE, 12'h555);
		queue_request(ACT_ACK, 12'hAAA);
		queue_request(ACT_RESERVED, 12'h555);
		wait_drained();

		// Pull the stop index under the running index: next sample ends the capture
		write_register(CFG_STOP_INDEX, {6'h3F, 14'd0});
		queue_request(ACT_SAMPLE, 12'h123);
		queue_request(ACT_SAMPLE, 12'hFFF);
		queue_request(ACT_START, 12'h000);
		queue_request(ACT_ACK, 12'h000);
		wait_drained();

		// Extremes: echo at index zero gives the floor distance
		write_register(CFG_ECHO_THRESHOLD, {8'hFF, 12'd0});
		write_register(CFG_DEAD_ZONE, {6'h3F, 14'd0});
		write_register(CFG_PEAK_END, {6'h00, 14'd16383});
		write_register(CFG_BASE_START, {6'h15, 14'd16283});
		write_register(CFG_STOP_INDEX, {6'h2A, 14'd0});
		write_register(CFG_SCALE_Q8, 20'hFFFFF);
		write_register(CFG_OFFSET_UM, 20'hFFFFF);
		write_register(CFG_UNUSED, 20'($urandom));
		queue_request(ACT_START, 12'h000);
		queue_request(ACT_SAMPLE, 12'hFFF);
		queue_request(ACT_SAMPLE, 12'h000);
		queue_request(ACT_ACK, 12'h000);
		wait_drained();

		// Unreachable threshold and dead zone, partial baseline window
		write_register(CFG_ECHO_THRESHOLD, {8'h00, 12'd4095});
		write_register(CFG_DEAD_ZONE, {6'h00, 14'd16383});
		write_register(CFG_PEAK_END, {6'h3F, 14'd0});
		write_register(CFG_BASE_START, {6'h3F, 14'd0});
		write_register(CFG_STOP_INDEX, {6'h00, 14'd2});
		write_register(CFG_SCALE_Q8, 20'h00000);
		write_register(CFG_OFFSET_UM, 20'h00000);
		queue_request(ACT_START, 12'h000);
		repeat (4) queue_request(ACT_SAMPLE, 12'hFFF);
		queue_request(ACT_ACK, 12'h000);

		// Random phases: fresh settings, then a well-formed capture with stray requests
		stop_at = planned + RANDOM_ITEMS;
		while (planned < stop_at) begin
			wait_drained();
			if ($urandom_range(4) == 0) begin
				// long enough to fill the baseline window, or stop just short of it
				bstart = $urandom_range(0, 12);
				stop = bstart + $urandom_range(90, 110);
			end else begin
				stop = $urandom_range(0, 40);
				bstart = $urandom_range(1) ? $urandom_range(0, 50) : $urandom_range(0, 16283);
			end
			case ($urandom_range(5))
				0:       thr = 0;
				1:       thr = 4095;
				default: thr = $urandom_range(0, 400);
			endcase
			dead = $urandom_range(0, stop + 3);
			pend = ($urandom_range(7) == 0) ? 16383 : $urandom_range(0, stop + 3);
			scale = $urandom_range(0, 20'hFFFFF);
			case ($urandom_range(2))
				0:       offs = 0;
				1:       offs = $urandom_range(0, 50000);
				default: offs = $urandom_range(0, 20'hFFFFF);
			endcase
			write_register(CFG_ECHO_THRESHOLD, {8'($urandom), 12'(thr)});
			write_register(CFG_DEAD_ZONE, {6'($urandom), 14'(dead)});
			write_register(CFG_PEAK_END, {6'($urandom), 14'(pend)});
			write_register(CFG_BASE_START, {6'($urandom), 14'(bstart)});
			write_register(CFG_STOP_INDEX, {6'($urandom), 14'(stop)});
			write_register(CFG_SCALE_Q8, 20'(scale));
			write_register(CFG_OFFSET_UM, 20'(offs));

			// noise while idle
			if ($urandom_range(3) == 0) begin
				queue_request(($urandom_range(1) != 0) ? ACT_SAMPLE : stray_action(),
					12'($urandom));
			end
			queue_request(ACT_START, 12'($urandom));
			// mostly quiet samples with occasional bursts; the last one closes the capture
			for (int k = 0; k < stop + 2; k++) begin
				if ($urandom_range(99) < 6) begin
					queue_request(stray_action(), 12'($urandom));
				end
				queue_request(ACT_SAMPLE, ($urandom_range(9) == 0) ?
					12'($urandom) : 12'($urandom_range(0, 255)));
			end
			if ($urandom_range(2) == 0) begin
				queue_request(ACT_SAMPLE, 12'($urandom));
				queue_request(ACT_START, 12'($urandom));
			end
			queue_request(ACT_ACK, 12'($urandom));
		end

		wait_drained();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/uerd_pkg.sv
hw/rtl/uerd_cfg_regs.sv
hw/rtl/uerd_dist.sv
hw/rtl/uerd_core.sv
hw/rtl/ultrasonic_echo_range_detector.sv
hw/rtl/uerd_checker.sv
sim/testbench.sv
